/* hdl/lst_pkg.sv */
// Shared types and constants of the latency statistics table.
`default_nettype none
package lst_pkg;

  // Table size default.
  localparam int KEYS_DEFAULT = 64;

  // Operation codes.
  localparam logic [2:0] FUNC_BEGIN      = 3'd0;
  localparam logic [2:0] FUNC_END        = 3'd1;
  localparam logic [2:0] FUNC_ADD_SAMPLE = 3'd2;
  localparam logic [2:0] FUNC_ADD_COUNT  = 3'd3;
  localparam logic [2:0] FUNC_DELETE     = 3'd4;
  localparam logic [2:0] FUNC_READ       = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD_LOW  = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD_MID  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD_HIGH = 2'd2;

  // Threshold reset values, in microseconds.
  localparam logic [31:0] THRESHOLD_LOW_RESET  = 32'd10000;
  localparam logic [31:0] THRESHOLD_MID_RESET  = 32'd50000;
  localparam logic [31:0] THRESHOLD_HIGH_RESET = 32'd80000;

  localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
  localparam logic [63:0] ONE_HOUR_USEC = 64'd3600000000;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  key_index;
    logic [31:0] start_sec;
    logic [19:0] start_usec;
    logic [31:0] end_sec;
    logic [19:0] end_usec;
    logic [31:0] sample_count;
  } req_t;

  typedef struct packed {
    logic        entry_present;
    logic [31:0] event_total;
    logic [63:0] time_total;
    logic [63:0] time_average;
    logic [63:0] time_max;
    logic [63:0] time_min;
    logic [31:0] over_low_count;
    logic [31:0] over_mid_count;
    logic [31:0] over_high_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

endpackage
`default_nettype wire

/* hdl/lst_channels.sv */
// Valid/ready channel interfaces for requests, responses and register writes.
`default_nettype none
interface lst_req_if;
  logic          valid;
  logic          ready;
  lst_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lst_rsp_if;
  logic          valid;
  logic          ready;
  lst_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lst_cfg_if;
  logic          valid;
  logic          ready;
  lst_pkg::cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/latency_stats_table.sv */
// Latency statistics table: per-key sample statistics in one wide entry memory.
//
// Keeps timing statistics for KEYS entries addressed by key_index. Each request reads
// one entry word; one that changes the entry is a read-modify-write: the word is worked
// on by a small sequencer that drives one shared 64-bit add/subtract unit (plus one
// 33x21 multiplier for the seconds-to-microseconds step), and written back. A request
// that does nothing (unused code, key outside the table, end on an absent entry) ends
// after the fetch; end and add_sample run thirteen steps of the shared unit, and a read
// of an entry with a nonzero event total runs a restoring 64/32 divide for the average
// at one quotient bit per cycle on the same unit. A response sits in an output
// register, so a new request may be taken while it waits; only a read that finishes
// while the previous response is still untaken holds. After reset a clearing pass
// marks every entry absent, one per cycle, before the first request is taken;
// register writes are taken throughout.
`default_nettype none
module latency_stats_table #(
  parameter int KEYS = lst_pkg::KEYS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  lst_req_if.sink     req,
  lst_rsp_if.source   rsp,
  lst_cfg_if.sink     cfg
);

  localparam int AW     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int KW     = (AW > 6) ? AW : 6;
  localparam int DIV_STEPS = 64;
  localparam int DCW    = $clog2(DIV_STEPS);

  // One table entry as held in memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] bsec;
    logic [19:0] busec;
    logic [31:0] events;
    logic [63:0] ttime;
    logic [63:0] tmax;
    logic [63:0] tmin;
    logic [31:0] slow_low;
    logic [31:0] slow_mid;
    logic [31:0] slow_high;
  } entry_t;

  localparam entry_t FRESH = '{
    valid: 1'b1, bsec: 32'd0, busec: 20'd0, events: 32'd0, ttime: 64'd0,
    tmax: 64'd0, tmin: lst_pkg::ONE_HOUR_USEC,
    slow_low: 32'd0, slow_mid: 32'd0, slow_high: 32'd0};

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FETCH,
    S_DIFF_S, S_MUL, S_DIFF_U, S_SUM, S_MAX, S_MIN,
    S_THR_LOW, S_THR_MID, S_THR_HIGH, S_TIME,
    S_SLOW_LOW, S_SLOW_MID, S_SLOW_HIGH, S_EVT,
    S_DIV, S_WRITE, S_RESULT
  } state_t;

  state_t        state;
  lst_pkg::req_t op;
  logic          in_table;
  entry_t        ent;
  logic [63:0]   dur;
  logic [63:0]   tmp;
  logic [2:0]    ge;
  logic [31:0]   div_rem;
  logic [63:0]   div_quo;
  logic [DCW-1:0] div_cnt;
  logic [AW-1:0] clr_addr;
  lst_pkg::rsp_t rsp_q;
  logic          rsp_valid;

  logic [31:0]   thr_low;
  logic [31:0]   thr_mid;
  logic [31:0]   thr_high;

  // Entry memory.
  entry_t        mem [KEYS];
  entry_t        rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [KW-1:0] req_key_w;
  logic [KW-1:0] op_key_w;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] op_addr;
  logic          req_in_table;

  // Fetched word as begin and delete leave it.
  entry_t        base_ent;
  entry_t        begin_ent;
  entry_t        del_ent;

  // Shared add/subtract unit and multiplier.
  logic [63:0]        alu_a;
  logic [63:0]        alu_b;
  logic               alu_sub;
  logic [64:0]        alu_sum;
  logic               alu_carry;
  logic signed [53:0] mul_prod;
  logic [31:0]        src_sec;
  logic [19:0]        src_usec;

  logic req_fire;
  logic rsp_fire;
  logic rsp_load;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_q;
  assign rsp_fire  = rsp_valid && rsp.ready;
  assign rsp_load  = (state == S_RESULT) && (!rsp_valid || rsp.ready);
  assign cfg.ready = 1'b1;

  // Key to address; keys at or above KEYS are outside the table.
  assign req_key_w    = KW'(req.payload.key_index);
  assign op_key_w     = KW'(op.key_index);
  assign rd_addr      = req_key_w[AW-1:0];
  assign op_addr      = op_key_w[AW-1:0];
  assign req_in_table = (32'(req.payload.key_index) < 32'(KEYS));

  // Clearing pass writes absent words, otherwise write back the working entry.
  assign mem_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : op_addr;
  assign mem_wdata = (state == S_CLEAR) ? entry_t'('0) : ent;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Create an absent entry on first use; begin then stamps its start time.
  always_comb begin
    base_ent        = rd_data.valid ? rd_data : FRESH;
    begin_ent       = base_ent;
    begin_ent.bsec  = op.start_sec;
    begin_ent.busec = op.start_usec;
    del_ent         = rd_data;
    del_ent.valid   = 1'b0;
  end

  // End measures from the stored begin time, add_sample from the request.
  assign src_sec  = (op.func == lst_pkg::FUNC_END) ? ent.bsec  : op.start_sec;
  assign src_usec = (op.func == lst_pkg::FUNC_END) ? ent.busec : op.start_usec;

  // Seconds difference is a 33-bit signed value; scale to microseconds.
  assign mul_prod = $signed(dur[32:0]) * $signed({1'b0, lst_pkg::USEC_PER_SEC});

  always_comb begin
    alu_a   = 64'd0;
    alu_b   = 64'd0;
    alu_sub = 1'b0;
    unique case (state)
      S_DIFF_S: begin
        alu_a   = {32'd0, op.end_sec};
        alu_b   = {32'd0, src_sec};
        alu_sub = 1'b1;
      end
      S_DIFF_U: begin
        alu_a   = {44'd0, op.end_usec};
        alu_b   = {44'd0, src_usec};
        alu_sub = 1'b1;
      end
      S_SUM: begin
        alu_a = dur;
        alu_b = tmp;
      end
      S_MAX: begin
        alu_a   = ent.tmax;
        alu_b   = dur;
        alu_sub = 1'b1;
      end
      S_MIN: begin
        alu_a   = dur;
        alu_b   = ent.tmin;
        alu_sub = 1'b1;
      end
      S_THR_LOW: begin
        alu_a   = dur;
        alu_b   = {32'd0, thr_low};
        alu_sub = 1'b1;
      end
      S_THR_MID: begin
        alu_a   = dur;
        alu_b   = {32'd0, thr_mid};
        alu_sub = 1'b1;
      end
      S_THR_HIGH: begin
        alu_a   = dur;
        alu_b   = {32'd0, thr_high};
        alu_sub = 1'b1;
      end
      S_TIME: begin
        alu_a = ent.ttime;
        alu_b = dur;
      end
      S_SLOW_LOW: begin
        alu_a = {32'd0, ent.slow_low};
        alu_b = {32'd0, op.sample_count};
      end
      S_SLOW_MID: begin
        alu_a = {32'd0, ent.slow_mid};
        alu_b = {32'd0, op.sample_count};
      end
      S_SLOW_HIGH: begin
        alu_a = {32'd0, ent.slow_high};
        alu_b = {32'd0, op.sample_count};
      end
      S_EVT: begin
        alu_a = {32'd0, ent.events};
        alu_b = {32'd0, op.sample_count};
      end
      S_DIV: begin
        // Trial subtract of the divisor from the shifted partial remainder.
        alu_a   = {31'd0, div_rem, div_quo[63]};
        alu_b   = {32'd0, ent.events};
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Carry out set on a subtract means no borrow: a >= b.
  assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {64{alu_sub}}} + 65'(alu_sub);
  assign alu_carry = alu_sum[64];

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_low  <= lst_pkg::THRESHOLD_LOW_RESET;
      thr_mid  <= lst_pkg::THRESHOLD_MID_RESET;
      thr_high <= lst_pkg::THRESHOLD_HIGH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.payload.index)
        lst_pkg::CFG_THRESHOLD_LOW:  thr_low  <= cfg.payload.data;
        lst_pkg::CFG_THRESHOLD_MID:  thr_mid  <= cfg.payload.data;
        lst_pkg::CFG_THRESHOLD_HIGH: thr_high <= cfg.payload.data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, working registers and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response once transferred, unless a new one loads at the same edge.
      if (rsp_fire && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(KEYS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end

        S_IDLE: begin
          if (req_fire) begin
            op       <= req.payload;
            in_table <= req_in_table;
            state    <= S_FETCH;
          end
        end

        S_FETCH: begin
          unique case (op.func)
            lst_pkg::FUNC_BEGIN: begin
              if (in_table) begin
                ent   <= begin_ent;
                state <= S_WRITE;
              end else begin
                state <= S_IDLE;
              end
            end
            lst_pkg::FUNC_END: begin
              if (in_table && rd_data.valid) begin
                ent   <= rd_data;
                state <= S_DIFF_S;
              end else begin
                state <= S_IDLE;
              end
            end
            lst_pkg::FUNC_ADD_SAMPLE: begin
              if (in_table) begin
                ent   <= base_ent;
                state <= S_DIFF_S;
              end else begin
                state <= S_IDLE;
              end
            end
            lst_pkg::FUNC_ADD_COUNT: begin
              if (in_table) begin
                ent   <= base_ent;
                state <= S_EVT;
              end else begin
                state <= S_IDLE;
              end
            end
            lst_pkg::FUNC_DELETE: begin
              if (in_table) begin
                ent   <= del_ent;
                state <= S_WRITE;
              end else begin
                state <= S_IDLE;
              end
            end
            lst_pkg::FUNC_READ: begin
              div_rem <= 32'd0;
              div_cnt <= '0;
              if (in_table && rd_data.valid) begin
                ent <= rd_data;
                if (rd_data.events == 32'd0) begin
                  div_quo <= 64'd0;
                  state   <= S_RESULT;
                end else begin
                  div_quo <= rd_data.ttime;
                  state   <= S_DIV;
                end
              end else begin
                // Absent entry answers with every field zero.
                ent     <= '0;
                div_quo <= 64'd0;
                state   <= S_RESULT;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_DIFF_S: begin
          dur   <= alu_sum[63:0];
          state <= S_MUL;
        end
        S_MUL: begin
          dur   <= {{10{mul_prod[53]}}, mul_prod};
          state <= S_DIFF_U;
        end
        S_DIFF_U: begin
          tmp   <= alu_sum[63:0];
          state <= S_SUM;
        end
        S_SUM: begin
          dur   <= alu_sum[63:0];
          state <= S_MAX;
        end
        S_MAX: begin
          if (!alu_carry) begin
            ent.tmax <= dur;
          end
          state <= S_MIN;
        end
        S_MIN: begin
          if (!alu_carry) begin
            ent.tmin <= dur;
          end
          state <= S_THR_LOW;
        end
        S_THR_LOW: begin
          ge[0] <= alu_carry;
          state <= S_THR_MID;
        end
        S_THR_MID: begin
          ge[1] <= alu_carry;
          state <= S_THR_HIGH;
        end
        S_THR_HIGH: begin
          ge[2] <= alu_carry;
          state <= S_TIME;
        end
        S_TIME: begin
          ent.ttime <= alu_sum[63:0];
          state     <= S_SLOW_LOW;
        end
        S_SLOW_LOW: begin
          if (ge[0]) begin
            ent.slow_low <= alu_sum[31:0];
          end
          state <= S_SLOW_MID;
        end
        S_SLOW_MID: begin
          if (ge[1]) begin
            ent.slow_mid <= alu_sum[31:0];
          end
          state <= S_SLOW_HIGH;
        end
        S_SLOW_HIGH: begin
          if (ge[2]) begin
            ent.slow_high <= alu_sum[31:0];
          end
          state <= S_EVT;
        end
        S_EVT: begin
          ent.events <= alu_sum[31:0];
          state      <= S_WRITE;
        end

        S_DIV: begin
          // Restoring divide: one quotient bit per cycle, shifted in at the bottom.
          if (alu_carry) begin
            div_rem <= alu_sum[31:0];
          end else begin
            div_rem <= {div_rem[30:0], div_quo[63]};
          end
          div_quo <= {div_quo[62:0], alu_carry};
          if (div_cnt == DCW'(DIV_STEPS - 1)) begin
            state <= S_RESULT;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end

        S_WRITE: begin
          state <= S_IDLE;
        end

        S_RESULT: begin
          // Hold until the previous response has gone.
          if (rsp_load) begin
            rsp_q <= '{
              entry_present:   ent.valid,
              event_total:     ent.events,
              time_total:      ent.ttime,
              time_average:    div_quo,
              time_max:        ent.tmax,
              time_min:        ent.tmin,
              over_low_count:  ent.slow_low,
              over_mid_count:  ent.slow_mid,
              over_high_count: ent.slow_high};
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_latency_stats_table.sv */
// Self-checking testbench for the latency statistics table: directed rows, then random traffic.
module tb_latency_stats_table;
  timeunit 1ns;
  timeprecision 1ps;

  import lst_pkg::*;

  localparam int KEYS = KEYS_DEFAULT;
  // Run limit in clock cycles.
  localparam int LIMIT = 1000000;
  // Quiet cycles before a register write or the end of the run; covers the longest
  // request that leaves no response behind (end and add_sample).
  localparam int SETTLE = 40;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int PHASES = 6;

  // Codes the block must ignore.
  localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;

  // One directed row: the request, and a typed-in response where it is obvious.
  typedef struct packed {
    req_t item;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  lst_req_if req_ch ();
  lst_rsp_if rsp_ch ();
  lst_cfg_if cfg_ch ();

  latency_stats_table #(
    .KEYS(KEYS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Mirror of the table contents and the thresholds.
  logic        live      [KEYS];
  logic [31:0] beg_s     [KEYS];
  logic [19:0] beg_u     [KEYS];
  logic [31:0] ev_tot    [KEYS];
  logic [63:0] tm_tot    [KEYS];
  logic [63:0] tm_max    [KEYS];
  logic [63:0] tm_min    [KEYS];
  logic [31:0] slow_cnt  [KEYS][3];
  logic [31:0] thr       [3];

  rsp_t     pending_reads [$];
  dir_row_t dir_rows      [$];

  int  err_count;
  int  items_sent;
  int  reads_checked;
  int  settings_used;
  int  cycles;
  int  stall_left;
  bit  idle_on;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Duration in microseconds, everything modulo 2^64.
  function automatic logic [63:0] span_us(input logic [31:0] ss, input logic [19:0] su,
                                          input logic [31:0] es, input logic [19:0] eu);
    logic [63:0] ds;
    logic [63:0] du;
    ds = {32'd0, es} - {32'd0, ss};
    du = {44'd0, eu} - {44'd0, su};
    return ds * {44'd0, USEC_PER_SEC} + du;
  endfunction

  // First use of an absent entry: zero totals, min at one hour, begin time zero.
  function automatic void create_entry(input logic [5:0] k);
    if (!live[k]) begin
      live[k]        = 1'b1;
      beg_s[k]       = '0;
      beg_u[k]       = '0;
      ev_tot[k]      = '0;
      tm_tot[k]      = '0;
      tm_max[k]      = '0;
      tm_min[k]      = ONE_HOUR_USEC;
      slow_cnt[k][0] = '0;
      slow_cnt[k][1] = '0;
      slow_cnt[k][2] = '0;
    end
  endfunction

  // Fold one sample of cnt events lasting d microseconds into entry k.
  function automatic void fold_sample(input logic [5:0] k, input logic [63:0] d,
                                      input logic [31:0] cnt);
    ev_tot[k] = ev_tot[k] + cnt;
    if (d > tm_max[k]) tm_max[k] = d;
    if (d < tm_min[k]) tm_min[k] = d;
    for (int i = 0; i < 3; i++) begin
      if (d >= {32'd0, thr[i]}) slow_cnt[k][i] = slow_cnt[k][i] + cnt;
    end
    tm_tot[k] = tm_tot[k] + d;
  endfunction

  // Apply one request to the mirror; returns 1 when it yields a response.
  function automatic bit table_step(input req_t r, output rsp_t res);
    logic [5:0] k;
    k   = r.key_index;
    res = '0;
    case (r.func)
      FUNC_BEGIN: begin
        create_entry(k);
        beg_s[k] = r.start_sec;
        beg_u[k] = r.start_usec;
      end
      FUNC_END: begin
        // an end on an absent entry is dropped
        if (live[k])
          fold_sample(k, span_us(beg_s[k], beg_u[k], r.end_sec, r.end_usec), r.sample_count);
      end
      FUNC_ADD_SAMPLE: begin
        create_entry(k);
        fold_sample(k, span_us(r.start_sec, r.start_usec, r.end_sec, r.end_usec),
                    r.sample_count);
      end
      FUNC_ADD_COUNT: begin
        create_entry(k);
        ev_tot[k] = ev_tot[k] + r.sample_count;
      end
      FUNC_DELETE: live[k] = 1'b0;
      FUNC_READ: begin
        if (live[k]) begin
          res.entry_present   = 1'b1;
          res.event_total     = ev_tot[k];
          res.time_total      = tm_tot[k];
          res.time_average    = (ev_tot[k] != 0) ? tm_tot[k] / {32'd0, ev_tot[k]} : 64'd0;
          res.time_max        = tm_max[k];
          res.time_min        = tm_min[k];
          res.over_low_count  = slow_cnt[k][0];
          res.over_mid_count  = slow_cnt[k][1];
          res.over_high_count = slow_cnt[k][2];
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t mk_req(input logic [2:0] func, input logic [5:0] key,
                                  input logic [31:0] ss, input logic [19:0] su,
                                  input logic [31:0] es, input logic [19:0] eu,
                                  input logic [31:0] cnt);
    req_t r;
    r.func         = func;
    r.key_index    = key;
    r.start_sec    = ss;
    r.start_usec   = su;
    r.end_sec      = es;
    r.end_usec     = eu;
    r.sample_count = cnt;
    return r;
  endfunction

  // Random microseconds part of a timestamp.
  function automatic logic [19:0] pick_usec();
    return 20'($urandom_range(0, 999999));
  endfunction

  // Timestamp span microseconds after (s, u); seconds wrap at 32 bits.
  function automatic void later_time(input logic [31:0] s, input logic [19:0] u,
                                     input logic [63:0] span,
                                     output logic [31:0] es, output logic [19:0] eu);
    logic [63:0] total;
    total = {44'd0, u} + span;
    es    = s + 32'(total / {44'd0, USEC_PER_SEC});
    eu    = 20'(total % {44'd0, USEC_PER_SEC});
  endfunction

  // Durations cluster on the thresholds so that both sides of each compare get hit.
  function automatic logic [63:0] pick_span();
    logic [63:0] t;
    case ($urandom_range(0, 5))
      0, 1: begin
        t = {32'd0, thr[$urandom_range(0, 2)]};
        return t + $urandom_range(0, 2) - 64'd1;
      end
      2, 3: return 64'($urandom_range(0, 200000));
      4:    return 64'($urandom);
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    return ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20));
  endfunction

  // Mostly a small pool of keys so that entries build up history.
  function automatic logic [5:0] pick_key();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, KEYS - 1))
                                       : 6'($urandom_range(0, 7));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers; every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until the transfer, then predict its response.
  task automatic send_req(input req_t r, input bit typed = 1'b0, input rsp_t want = '0);
    int   gap;
    rsp_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.payload = r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (table_step(r, res)) pending_reads.push_back(typed ? want : res);
    if (r.func <= FUNC_READ) items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_ch.valid         = 1'b1;
    cfg_ch.payload.index = idx;
    cfg_ch.payload.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    thr[idx] = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained(input bit settle);
    req_ch.valid = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE) @(negedge clk);
  endtask

  // Random traffic: mostly well-formed begin/end and sample sequences, some noise.
  task automatic random_phase(input int target, input bit allow_idle);
    int         start_count;
    int         seqs;
    int         kind;
    logic [5:0] k;
    logic [31:0] es;
    logic [19:0] eu;
    logic [31:0] ss;
    logic [19:0] su;
    start_count = items_sent;
    seqs = 0;
    while (items_sent - start_count < target) begin
      // alternate stretches with and without idling
      if (seqs % 25 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      seqs++;
      k    = pick_key();
      kind = $urandom_range(0, 19);
      if (kind < 7) begin
        // begin then end on the same entry; now and then the end strays to another key
        send_req(mk_req(FUNC_BEGIN, k, $urandom, pick_usec(), $urandom,
                        pick_usec(), $urandom));
        if ($urandom_range(0, 7) == 0) k = pick_key();
        later_time(beg_s[k], beg_u[k], pick_span(), es, eu);
        send_req(mk_req(FUNC_END, k, $urandom, pick_usec(), es, eu,
                        pick_count()));
        if ($urandom_range(0, 1) == 0)
          send_req(mk_req(FUNC_READ, k, $urandom, 0, $urandom, 0, $urandom));
      end else if (kind < 12) begin
        repeat ($urandom_range(1, 3)) begin
          ss = $urandom;
          su = pick_usec();
          later_time(ss, su, pick_span(), es, eu);
          send_req(mk_req(FUNC_ADD_SAMPLE, k, ss, su, es, eu, pick_count()));
        end
        if ($urandom_range(0, 1) == 0)
          send_req(mk_req(FUNC_READ, k, $urandom, 0, $urandom, 0, $urandom));
      end else if (kind < 14) begin
        send_req(mk_req(FUNC_ADD_COUNT, k, $urandom, pick_usec(), $urandom,
                        pick_usec(), pick_count()));
      end else if (kind < 16) begin
        send_req(mk_req(FUNC_READ, k, $urandom, pick_usec(), $urandom,
                        pick_usec(), $urandom));
      end else if (kind < 17) begin
        send_req(mk_req(FUNC_DELETE, k, $urandom, 0, $urandom, 0, $urandom));
        if ($urandom_range(0, 1) == 0)
          send_req(mk_req(FUNC_READ, k, $urandom, 0, $urandom, 0, $urandom));
      end else begin
        // noise: any code, any key, unrelated timestamps
        send_req(mk_req(3'($urandom_range(0, 7)), 6'($urandom_range(0, KEYS - 1)), $urandom,
                        pick_usec(), $urandom, pick_usec(),
                        $urandom));
      end
      // hold the sender off now and then until every response is back
      if ($urandom_range(0, 149) == 0) wait_drained(1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  // Drop ready in bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   = stall_left - 1;
      rsp_ch.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left   = $urandom_range(0, 8);
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Check every response transfer against the oldest outstanding read.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (pending_reads.size() == 0) begin
        err_count++;
        $display("%0t: response with no read outstanding: expected none, got %h", $time, got);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        cmp_field("entry_present", 64'(want.entry_present), 64'(got.entry_present));
        cmp_field("event_total", 64'(want.event_total), 64'(got.event_total));
        cmp_field("time_total", want.time_total, got.time_total);
        cmp_field("time_average", want.time_average, got.time_average);
        cmp_field("time_max", want.time_max, got.time_max);
        cmp_field("time_min", want.time_min, got.time_min);
        cmp_field("over_low_count", 64'(want.over_low_count), 64'(got.over_low_count));
        cmp_field("over_mid_count", 64'(want.over_mid_count), 64'(got.over_mid_count));
        cmp_field("over_high_count", 64'(want.over_high_count), 64'(got.over_high_count));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_latency_stats_table: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rsp_t absent;
    rsp_t fresh5;
    rsp_t wrapped;
    logic [31:0] t_low;
    logic [31:0] t_mid;
    logic [31:0] t_high;

    clk            = 1'b0;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    err_count      = 0;
    items_sent     = 0;
    reads_checked  = 0;
    settings_used  = 0;
    cycles         = 0;
    stall_left     = 0;
    idle_on        = 1'b1;
    for (int k = 0; k < KEYS; k++) begin
      live[k]  = 1'b0;
      beg_s[k] = '0;
      beg_u[k] = '0;
    end
    thr[CFG_THRESHOLD_LOW]  = THRESHOLD_LOW_RESET;
    thr[CFG_THRESHOLD_MID]  = THRESHOLD_MID_RESET;
    thr[CFG_THRESHOLD_HIGH] = THRESHOLD_HIGH_RESET;

    // Responses obvious from the rules: an absent entry reads as all zero; a
    // fresh entry has only its event total set and min at one hour.
    absent                = '0;
    fresh5                = '0;
    fresh5.entry_present  = 1'b1;
    fresh5.event_total    = 32'd5;
    fresh5.time_min       = ONE_HOUR_USEC;
    wrapped               = fresh5;
    wrapped.event_total   = 32'd1;

    // Directed rows: fresh entries, absent entries, wrapping durations and totals,
    // the ignored codes, and an end with no begin.
    dir_rows.push_back('{mk_req(FUNC_READ, 0, 0, 0, 0, 0, 0), 1'b1, absent});
    dir_rows.push_back('{mk_req(FUNC_ADD_COUNT, 1, 0, 0, 0, 0, 5), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 1, 0, 0, 0, 0, 0), 1'b1, fresh5});
    dir_rows.push_back('{mk_req(FUNC_BEGIN, 2, 100, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_END, 2, 0, 0, 100, 20000, 3), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 2, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ADD_SAMPLE, 3, 32'hFFFF_FFFF, 999999, 0, 0,
                                32'hFFFF_FFFF), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ADD_SAMPLE, 3, 0, 0, 32'hFFFF_FFFF, 999999, 1),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 3, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_END, 4, 0, 0, 5, 0, 7), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 4, 0, 0, 0, 0, 0), 1'b1, absent});
    dir_rows.push_back('{mk_req(FUNC_DELETE, 5, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 5, 0, 0, 0, 0, 0), 1'b1, absent});
    dir_rows.push_back('{mk_req(FUNC_DELETE, 1, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 1, 0, 0, 0, 0, 0), 1'b1, absent});
    dir_rows.push_back('{mk_req(FUNC_UNUSED_6, 6, 32'hFFFF_FFFF, 999999, 32'hFFFF_FFFF,
                                999999, 32'hFFFF_FFFF), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_UNUSED_7, 7, 32'hFFFF_FFFF, 999999, 32'hFFFF_FFFF,
                                999999, 32'hFFFF_FFFF), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 6, 0, 0, 0, 0, 0), 1'b1, absent});
    dir_rows.push_back('{mk_req(FUNC_ADD_SAMPLE, 63, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 63, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ADD_COUNT, 9, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ADD_COUNT, 9, 0, 0, 0, 0, 2), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 9, 0, 0, 0, 0, 0), 1'b1, wrapped});
    dir_rows.push_back('{mk_req(FUNC_BEGIN, 2, 200, 999999, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_END, 2, 0, 0, 201, 0, 1), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_READ, 2, 0, 0, 0, 0, 0), 1'b0, '0});

    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      // Thresholds change only with the table idle.
      if (p != 0) wait_drained(1'b1);
      case (p)
        0: begin
          t_low  = THRESHOLD_LOW_RESET;
          t_mid  = THRESHOLD_MID_RESET;
          t_high = THRESHOLD_HIGH_RESET;
        end
        1: begin
          t_low  = 32'd0;
          t_mid  = 32'd0;
          t_high = 32'd0;
        end
        2: begin
          t_low  = 32'hFFFF_FFFF;
          t_mid  = 32'hFFFF_FFFF;
          t_high = 32'hFFFF_FFFF;
        end
        3: begin
          // independent draws, so the order of the three is not kept
          t_low  = $urandom_range(0, 150000);
          t_mid  = $urandom_range(0, 150000);
          t_high = $urandom_range(0, 150000);
        end
        4: begin
          t_low  = 32'd1;
          t_mid  = $urandom_range(0, 1000000);
          t_high = $urandom;
        end
        default: begin
          t_low  = $urandom_range(0, 60000);
          t_mid  = $urandom_range(30000, 120000);
          t_high = $urandom_range(60000, 200000);
        end
      endcase
      cfg_write(CFG_THRESHOLD_LOW, t_low);
      cfg_write(CFG_THRESHOLD_MID, t_mid);
      cfg_write(CFG_THRESHOLD_HIGH, t_high);
      settings_used++;

      if (p == 0) begin
        idle_on = 1'b1;
        foreach (dir_rows[i]) send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
      // Run the last phase flat out: no idling on either side.
      if (p == PHASES - 1) idle_on = 1'b0;
      random_phase(RANDOM_PER_PHASE, p != PHASES - 1);
    end

    // Let every outstanding read return, then give stragglers time to show up.
    idle_on = 1'b0;
    wait_drained(1'b1);

    $display("Covered %0d requests and %0d checked reads under %0d threshold settings,",
             items_sent, reads_checked, settings_used);
    $display("with sender gaps, response stalls and a final stretch without idling.");
    if (err_count == 0 && pending_reads.size() == 0) begin
      $display("tb_latency_stats_table: clean");
    end else begin
      $display("tb_latency_stats_table: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lst_pkg.sv
hdl/lst_channels.sv
hdl/latency_stats_table.sv
tb/sv/tb_latency_stats_table.sv
